FILE: src/primality_tester_assert.svh
// assertion macros used by the primality tester controller
// no dependencies
`ifndef PRIMALITY_TESTER_ASSERT_SVH
`define PRIMALITY_TESTER_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define PT_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define PT_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

FILE: src/pt_pkg.sv
// types and constants for the primality tester
// no dependencies
`default_nettype none
package pt_pkg;
   localparam int unsigned WitnessIdxWidth = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SPLIT,
      ST_WIT_INIT,
      ST_POW_STEP,
      ST_MUL_WAIT,
      ST_SQR_CHECK,
      ST_SQR_WAIT,
      ST_DONE
   } state_type;

   // multiplier operand select
   typedef enum logic [1:0] {
      MOP_ACC_BASE,
      MOP_BASE_BASE,
      MOP_X_X
   } mul_op_type;

   typedef struct packed {
      logic       load;      // capture number
      logic       split_step; // shift d right once, s++
      logic       wit_init;  // load acc=1, base=witness, e=d
      logic       mul_start;
      mul_op_type mul_op;
      logic       e_shift;   // e >>= 1
      logic       next_wit;
      logic       r_inc;
      logic       set_result;
      logic       result_val;
   } ctrl_type;

   typedef struct packed {
      logic small_done;  // decided without witnesses
      logic small_val;
      logic d_even;
      logic e_zero;
      logic e_lsb;
      logic mul_busy;
      logic mul_done;
      logic acc_is_one;
      logic x_is_nm1;
      logic r_last;      // r == s
      logic wit_last;
   } stat_type;

   function automatic logic [5:0] witness_base(input logic [WitnessIdxWidth-1:0] k);
      logic [5:0] b;
      unique case (k)
         4'd0:  b = 6'd2;
         4'd1:  b = 6'd3;
         4'd2:  b = 6'd5;
         4'd3:  b = 6'd7;
         4'd4:  b = 6'd11;
         4'd5:  b = 6'd13;
         4'd6:  b = 6'd17;
         4'd7:  b = 6'd19;
         4'd8:  b = 6'd23;
         4'd9:  b = 6'd29;
         4'd10: b = 6'd31;
         4'd11: b = 6'd37;
         default: b = 6'd2;
      endcase
      return b;
   endfunction
endpackage
`default_nettype wire

FILE: src/pt_mulmod.sv
// shift-and-add modular multiplier, one multiplier bit per cycle
// depends on nothing beyond its ports
`default_nettype none
module pt_mulmod #(
   parameter int unsigned W = 63
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] a,   // both operands below n
   input  wire logic [W-1:0] b,
   input  wire logic [W-1:0] n,
   output logic              busy,
   output logic              done,
   output logic [W-1:0]      prod
);
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [W-1:0] x_ff, x_in, y_ff, y_in, acc_ff, acc_in;
   logic [W:0]   sum_acc, sum_x;
   logic [W:0]   sub_acc, sub_x;

   always_comb begin
      sum_acc = {1'b0, acc_ff} + {1'b0, x_ff};
      sub_acc = sum_acc - {1'b0, n};
      sum_x   = {1'b0, x_ff} + {1'b0, x_ff};
      sub_x   = sum_x - {1'b0, n};
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in    = a;
         y_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (y_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (y_ff[0])
               acc_in = sub_acc[W] ? sum_acc[W-1:0] : sub_acc[W-1:0];
            x_in = sub_x[W] ? sum_x[W-1:0] : sub_x[W-1:0];
            y_in = y_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign prod = acc_ff;
endmodule
`default_nettype wire

FILE: src/pt_datapath.sv
// datapath: number, d/s split, exponentiation registers, witness index
// depends on pt_pkg and pt_mulmod
`default_nettype none
module pt_datapath #(
   parameter int unsigned NumberWidth  = 63,
   parameter int unsigned WitnessCount = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [NumberWidth-1:0] number_in,
   input  wire pt_pkg::ctrl_type       ctrl,
   output pt_pkg::stat_type            stat,
   output logic                        result
);
   import pt_pkg::*;
   localparam int unsigned SW = $clog2(NumberWidth + 1);
   localparam logic [WitnessIdxWidth-1:0] LastWit = WitnessIdxWidth'(WitnessCount - 1);

   logic [NumberWidth-1:0] n_ff, n_in, d_ff, d_in, e_ff, e_in;
   logic [NumberWidth-1:0] acc_ff, acc_in, base_ff, base_in;
   logic [SW-1:0]          s_ff, s_in, r_ff, r_in;
   logic [WitnessIdxWidth-1:0] k_ff, k_in;
   logic                   res_ff, res_in;
   logic [NumberWidth-1:0] ma, mb, prod, nm1, wb;
   logic                   mbusy, mdone, eq_wit;

   assign nm1 = n_ff - NumberWidth'(1);
   assign wb  = NumberWidth'(witness_base(k_ff));

   always_comb begin
      eq_wit = 1'b0;
      for (int i = 0; i < int'(WitnessCount); i++)
         if (n_ff == NumberWidth'(witness_base(WitnessIdxWidth'(i)))) eq_wit = 1'b1;
   end

   always_comb begin
      unique case (ctrl.mul_op)
         MOP_ACC_BASE:  begin ma = acc_ff;  mb = base_ff; end
         MOP_BASE_BASE: begin ma = base_ff; mb = base_ff; end
         default:       begin ma = acc_ff;  mb = acc_ff;  end
      endcase
   end

   pt_mulmod #(.W(NumberWidth)) u_mul (
      .clock(clock), .reset(reset), .start(ctrl.mul_start),
      .a(ma), .b(mb), .n(n_ff), .busy(mbusy), .done(mdone), .prod(prod)
   );

   always_comb begin
      n_in = n_ff; d_in = d_ff; s_in = s_ff; e_in = e_ff;
      acc_in = acc_ff; base_in = base_ff; k_in = k_ff; r_in = r_ff;
      res_in = res_ff;
      if (ctrl.load) begin
         n_in = number_in;
         d_in = number_in - NumberWidth'(1);
         s_in = '0;
         k_in = '0;
      end
      if (ctrl.split_step) begin
         d_in = d_ff >> 1;
         s_in = s_ff + SW'(1);
      end
      if (ctrl.wit_init) begin
         acc_in  = NumberWidth'(1);
         base_in = wb;   // a base is not reduced mod n here and can exceed a small n
         e_in    = d_ff;
         r_in    = '0;
      end
      if (mdone) begin
         // acc holds the square of x during the squaring phase
         if (ctrl.mul_op == MOP_BASE_BASE) base_in = prod;
         else acc_in = prod;
      end
      if (ctrl.e_shift) e_in = e_ff >> 1;
      if (ctrl.r_inc)   r_in = r_ff + SW'(1);
      if (ctrl.next_wit) k_in = k_ff + WitnessIdxWidth'(1);
      if (ctrl.set_result) res_in = ctrl.result_val;
   end

   always_ff @(posedge clock) begin
      if (reset) res_ff <= 1'b0;
      else       res_ff <= res_in;
      n_ff <= n_in; d_ff <= d_in; s_ff <= s_in; e_ff <= e_in;
      acc_ff <= acc_in; base_ff <= base_in; k_ff <= k_in; r_ff <= r_in;
   end

   always_comb begin
      stat.small_done = (n_ff <= NumberWidth'(3)) || !n_ff[0] || eq_wit;
      stat.small_val  = ((n_ff == NumberWidth'(2)) || (n_ff == NumberWidth'(3)) ||
                         (eq_wit && n_ff[0]));
      stat.d_even     = !d_ff[0];
      stat.e_zero     = (e_ff == '0);
      stat.e_lsb      = e_ff[0];
      stat.mul_busy   = mbusy;
      stat.mul_done   = mdone;
      stat.acc_is_one = (acc_ff == NumberWidth'(1));
      stat.x_is_nm1   = (acc_ff == nm1);
      stat.r_last     = (r_ff == s_ff);
      stat.wit_last   = (k_ff == LastWit);
   end
   assign result = res_ff;
endmodule
`default_nettype wire

FILE: src/pt_controller.sv
// controller state machine for the primality tester
// depends on pt_pkg and primality_tester_assert.svh
`default_nettype none
`include "primality_tester_assert.svh"
module pt_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire pt_pkg::stat_type stat,
   output pt_pkg::ctrl_type      ctrl
);
   import pt_pkg::*;
   state_type state_ff, state_in;
   logic      mul_op_sel_ff, mul_op_sel_in; // 1: base squaring pending, or a squaring done in the squaring phase

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mul_op_sel_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mul_op_sel_ff <= mul_op_sel_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      mul_op_sel_in = mul_op_sel_ff;
      ctrl          = '0;
      ctrl.mul_op   = MOP_ACC_BASE;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load = 1'b1;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.small_done) begin
               ctrl.set_result = 1'b1;
               ctrl.result_val = stat.small_val;
               state_in        = ST_DONE;
            end else state_in = ST_SPLIT;
         end
         ST_SPLIT: begin
            if (stat.d_even) ctrl.split_step = 1'b1;
            else begin
               ctrl.wit_init = 1'b1;
               state_in      = ST_POW_STEP;
            end
         end
         ST_WIT_INIT: begin
            ctrl.wit_init = 1'b1;
            mul_op_sel_in = 1'b0;
            state_in      = ST_POW_STEP;
         end
         ST_POW_STEP: begin
            // one exponent bit: optional acc*base, then base*base
            if (stat.e_zero) state_in = ST_SQR_CHECK;
            else if (stat.e_lsb && !mul_op_sel_ff) begin
               ctrl.mul_start = 1'b1;
               ctrl.mul_op    = MOP_ACC_BASE;
               mul_op_sel_in  = 1'b1;
               state_in       = ST_MUL_WAIT;
            end else begin
               ctrl.mul_start = 1'b1;
               ctrl.mul_op    = MOP_BASE_BASE;
               mul_op_sel_in  = 1'b0;
               state_in       = ST_MUL_WAIT;
            end
         end
         ST_MUL_WAIT: begin
            ctrl.mul_op = mul_op_sel_ff ? MOP_ACC_BASE : MOP_BASE_BASE;
            if (stat.mul_done) begin
               if (!mul_op_sel_ff) ctrl.e_shift = 1'b1;
               state_in = ST_POW_STEP;
            end
         end
         ST_SQR_CHECK: begin
            // n-1 only counts before the last squaring, 1 only before the first
            if ((stat.x_is_nm1 && !stat.r_last) || (stat.acc_is_one && !mul_op_sel_ff)) begin
               // witness passes
               if (stat.wit_last) begin
                  ctrl.set_result = 1'b1;
                  ctrl.result_val = 1'b1;
                  state_in        = ST_DONE;
               end else begin
                  ctrl.next_wit = 1'b1;
                  state_in      = ST_WIT_INIT;
               end
            end else if (stat.r_last) begin
               ctrl.set_result = 1'b1;
               ctrl.result_val = 1'b0;
               state_in        = ST_DONE;
            end else begin
               ctrl.mul_start = 1'b1;
               ctrl.mul_op    = MOP_X_X;
               mul_op_sel_in  = 1'b1;
               state_in       = ST_SQR_WAIT;
            end
         end
         ST_SQR_WAIT: begin
            ctrl.mul_op = MOP_X_X;
            if (stat.mul_done) begin
               ctrl.r_inc = 1'b1;
               state_in   = ST_SQR_CHECK;
            end
         end
         ST_DONE: begin
            rsp_valid     = 1'b1;
            mul_op_sel_in = 1'b0;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `PT_ASSERT_IMPL(a_mul_start_idle, clock, reset, ctrl.mul_start, !stat.mul_busy)
   `PT_ASSERT_NEXT(a_load_to_check, clock, reset, req_valid && req_ready, state_ff == ST_CHECK)
   `PT_ASSERT_IMPL(a_done_in_wait, clock, reset, stat.mul_done,
                   state_ff == ST_MUL_WAIT || state_ff == ST_SQR_WAIT)
endmodule
`default_nettype wire

FILE: src/primality_tester.sv
// Deterministic Miller-Rabin primality tester. One number is taken at a
// time; the answer is held on rsp_ until taken, and a new number is taken
// only after that. Small, even and witness-equal numbers are decided in the
// check state without witnesses. Otherwise each witness costs about
// (bits of d)*2+s modular products, each product working through its
// multiplier bit by bit, all in the single shared shift-and-add multiplier.
// depends on pt_pkg, pt_controller, pt_datapath
`default_nettype none
module primality_tester #(
   parameter int unsigned NUMBER_WIDTH  = 63,
   parameter int unsigned WITNESS_COUNT = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [62:0] req_number_to_test,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_prime_flag
);
   import pt_pkg::*;
   ctrl_type ctrl;
   stat_type stat;
   logic [NUMBER_WIDTH-1:0] num;

   assign num = req_number_to_test[NUMBER_WIDTH-1:0];

   pt_controller u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .stat(stat), .ctrl(ctrl)
   );

   pt_datapath #(.NumberWidth(NUMBER_WIDTH), .WitnessCount(WITNESS_COUNT)) u_dp (
      .clock(clock), .reset(reset), .number_in(num), .ctrl(ctrl), .stat(stat),
      .result(rsp_prime_flag)
   );
endmodule
`default_nettype wire
